// ----- rtl/csvfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_pkg: shared types and constants of the CSV field splitter
// Character codes, parser modes, result kinds and the state and result
// records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [7:0]  MaxFieldsReset = 8'd100;
  localparam logic [31:0] RowCountMax    = 32'hFFFF_FFFF;

  localparam logic FuncData = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  typedef enum logic [2:0] {
    MODE_LINE_START  = 3'd0,
    MODE_FIELD_START = 3'd1,
    MODE_UNQUOTED    = 3'd2,
    MODE_QUOTED      = 3'd3,
    MODE_AFTER_QUOTE = 3'd4,
    MODE_IGNORE      = 3'd5,
    MODE_DROP        = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_OK    = 2'd2,
    KIND_ROW_BAD   = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  field_cnt;
    logic [31:0] row_cnt;
    logic        trim;
    logic        trunc;
    logic        bad;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  field_index;
    logic [31:0] row_seq;
    logic        truncated;
  } result_t;

endpackage

// ----- rtl/csvfs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_if: channel interfaces of the CSV field splitter
// Byte request channel, result channel and configuration write channel,
// each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface csvfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [7:0]  field_index;
  logic [31:0] row_seq;
  logic        truncated;
  modport source (output valid, output kind, output out_byte, output field_index,
                  output row_seq, output truncated, input ready);
  modport sink   (input valid, input kind, input out_byte, input field_index,
                  input row_seq, input truncated, output ready);
endinterface

interface csvfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_cap;
  modport source (output valid, output field_cap, input ready);
  modport sink   (input valid, input field_cap, output ready);
endinterface

// ----- rtl/csvfs_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_step: per-byte parser step
// Combinational next state and optional result for one request.
// ----------------------------------------------------------------------------
module csvfs_step
  import csvfs_pkg::*;
(
  input  parse_state_t cur_i,
  input  logic         func_i,
  input  logic [7:0]   data_byte_i,
  input  logic [7:0]   field_cap_i,
  output parse_state_t nxt_o,
  output logic         res_valid_o,
  output result_t      res_o
);

  logic       eol;
  logic [7:0] limit;
  logic       do_begin;
  logic       do_content;
  logic       do_fend;
  logic       do_end;
  logic       end_cr;

  assign eol   = (data_byte_i == ChCr) || (data_byte_i == ChLf);
  assign limit = (field_cap_i == 8'd0) ? 8'd1 : field_cap_i;

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.row_seq = cur_i.row_cnt;
    do_begin    = 1'b0;
    do_content  = 1'b0;
    do_fend     = 1'b0;
    do_end      = 1'b0;
    end_cr      = 1'b0;

    if (func_i == FuncEnd) begin
      if (cur_i.mode == MODE_LINE_START || cur_i.mode == MODE_DROP) begin
        nxt_o.mode = MODE_LINE_START;
      end else begin
        do_end = 1'b1;
      end
    end else begin
      end_cr = (data_byte_i == ChCr);
      unique case (cur_i.mode)
        MODE_LINE_START: begin
          if (eol) nxt_o.mode = end_cr ? MODE_DROP : MODE_LINE_START;
          else     do_begin = 1'b1;
        end
        MODE_FIELD_START: begin
          if (eol) do_end = 1'b1;
          else     do_begin = 1'b1;
        end
        MODE_UNQUOTED: begin
          if (eol)                          do_end = 1'b1;
          else if (data_byte_i == ChComma)  do_fend = 1'b1;
          else                              do_content = 1'b1;
        end
        MODE_QUOTED: begin
          if (eol) begin
            nxt_o.bad = 1'b1;
            do_end    = 1'b1;
          end else if (data_byte_i == ChQuote) begin
            nxt_o.mode = MODE_AFTER_QUOTE;
          end else begin
            do_content = 1'b1;
          end
        end
        MODE_AFTER_QUOTE: begin
          if (eol) begin
            do_end = 1'b1;
          end else if (data_byte_i == ChComma) begin
            do_fend = 1'b1;
          end else begin
            nxt_o.bad  = 1'b1;
            nxt_o.mode = MODE_IGNORE;
          end
        end
        MODE_IGNORE: begin
          if (eol) do_end = 1'b1;
        end
        MODE_DROP: begin
          nxt_o.mode = (data_byte_i == ChLf) ? MODE_LINE_START : MODE_DROP;
        end
        default: begin
          nxt_o.mode = MODE_LINE_START;
        end
      endcase
    end

    // open a new field, or drop it past the limit
    if (do_begin) begin
      if (cur_i.field_cnt >= limit) begin
        nxt_o.trunc = 1'b1;
        nxt_o.mode  = MODE_IGNORE;
      end else begin
        nxt_o.field_cnt = cur_i.field_cnt + 8'd1;
        nxt_o.trim      = 1'b1;
        if (data_byte_i == ChQuote) begin
          nxt_o.mode = MODE_QUOTED;
        end else begin
          nxt_o.mode = MODE_UNQUOTED;
          if (data_byte_i == ChComma) do_fend = 1'b1;
          else                        do_content = 1'b1;
        end
      end
    end

    if (do_content) begin
      if (!(nxt_o.trim && data_byte_i == ChSpace)) begin
        nxt_o.trim        = 1'b0;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_CONTENT;
        res_o.out_byte    = data_byte_i;
        res_o.field_index = nxt_o.field_cnt - 8'd1;
      end
    end

    if (do_fend) begin
      res_valid_o       = 1'b1;
      res_o.kind        = KIND_FIELD_END;
      res_o.field_index = nxt_o.field_cnt - 8'd1;
      nxt_o.mode        = MODE_FIELD_START;
    end

    if (do_end) begin
      res_valid_o       = 1'b1;
      res_o.kind        = nxt_o.bad ? KIND_ROW_BAD : KIND_ROW_OK;
      res_o.field_index = nxt_o.field_cnt;
      res_o.truncated   = nxt_o.trunc;
      if (cur_i.row_cnt != RowCountMax) nxt_o.row_cnt = cur_i.row_cnt + 32'd1;
      nxt_o.field_cnt = 8'd0;
      nxt_o.trim      = 1'b1;
      nxt_o.trunc     = 1'b0;
      nxt_o.bad       = 1'b0;
      nxt_o.mode      = end_cr ? MODE_DROP : MODE_LINE_START;
    end
  end

endmodule

// ----- rtl/csv_field_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter: streaming splitter of comma-separated text
// Parses one byte per request into field content, field ends and row ends.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                   | accepted when
//   --------+-----+-------------------------------------------+--------------
//   req_i   | in  | func, data_byte                           | valid & ready
//   res_o   | out | kind, out_byte, field_index, row_seq,     | valid & ready
//           |     | truncated                                 |
//   cfg_i   | in  | field_cap                                 | valid & ready
//
// One request a cycle sustained while results are taken: a request is held in
// the input register, the parser step runs on it there and the result (if any)
// is held in the result register.
// Reset clears the parser state, the row counter (to one) and field_cap
// (to 100). A stalled result register holds the input stage; the input
// register frees itself the same cycle the result is taken.
//
module csv_field_splitter
  import csvfs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  csvfs_in_if.sink       req_i,
  csvfs_out_if.source    res_o,
  csvfs_cfg_if.sink      cfg_i
);

  // configuration register
  logic [7:0] field_cap_q;

  // input register
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;

  // parser state
  parse_state_t st_q, st_d;

  // result register
  logic    out_valid_q;
  result_t out_q;

  logic    step_valid;
  result_t step_res;
  logic    advance;

  // advance the input stage when the result register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  csvfs_step u_step (
    .cur_i        (st_q),
    .func_i       (in_func_q),
    .data_byte_i  (in_byte_q),
    .field_cap_i  (field_cap_q),
    .nxt_o        (st_d),
    .res_valid_o  (step_valid),
    .res_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_cap_q <= MaxFieldsReset;
    end else if (cfg_i.valid) begin
      field_cap_q <= cfg_i.field_cap;
    end
  end

  // capture a request whenever the input register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_func_q <= req_i.func;
      in_byte_q <= req_i.data_byte;
    end
  end

  // commit the parser state only when the step result can be stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode      <= MODE_LINE_START;
      st_q.field_cnt <= 8'd0;
      st_q.row_cnt   <= 32'd1;
      st_q.trim      <= 1'b1;
      st_q.trunc     <= 1'b0;
      st_q.bad       <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_valid;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_valid) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.out_byte    = out_q.out_byte;
  assign res_o.field_index = out_q.field_index;
  assign res_o.row_seq     = out_q.row_seq;
  assign res_o.truncated   = out_q.truncated;

endmodule
